// ===== rtl/bounded_linked_list_engine_macros.svh =====
// ----------------------------------------------------------------------------
// bounded linked list engine assertion macros
// concurrent check wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LINKED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_LINKED_LIST_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BLL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BLL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BLL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/bll_pkg.sv =====
// ----------------------------------------------------------------------------
// bll_pkg
// shared constants, field widths and cell control types of the list engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bll_pkg;

  // default sizes
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // transaction field widths
  localparam int unsigned ACTION_W    = 4;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned INDEX_W     = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_APPEND    = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_PREPEND   = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_DROP_TAIL = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_DROP_HEAD = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_INSERT    = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_ERASE     = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_FIND      = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_REVERSE   = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_READ      = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_CLEAR     = 4'd9;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  // per-cell operation
  typedef enum logic [2:0] {
    CO_HOLD,
    CO_INS,
    CO_DEL,
    CO_STACK,
    CO_COPY
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     at;    // cell sits at the target position
    logic     past;  // cell sits beyond the target position
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bll_cell.sv =====
// ----------------------------------------------------------------------------
// bll_cell
// one list position: a data word and a spare word used while reversing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bll_cell import bll_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire cell_ctl_t             ctl_i,
  input  wire logic [DATA_WIDTH-1:0] key_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  input  wire logic [DATA_WIDTH-1:0] spare_left_i,
  output logic      [DATA_WIDTH-1:0] data_o,
  output logic      [DATA_WIDTH-1:0] spare_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] spare_q, spare_d;

  always_comb begin
    data_d  = data_q;
    spare_d = spare_q;
    case (ctl_i.op)
      CO_INS: begin
        if (ctl_i.past) begin
          data_d = left_i;
        end else if (ctl_i.at) begin
          data_d = key_i;
        end
      end
      CO_DEL: begin
        if (ctl_i.at || ctl_i.past) begin
          data_d = right_i;
        end
      end
      CO_STACK: begin
        // rotate toward the head, push the old head onto the spare stack
        if (ctl_i.at || ctl_i.past) begin
          data_d = right_i;
        end
        spare_d = spare_left_i;
      end
      CO_COPY: begin
        data_d = spare_q;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    spare_q <= spare_d;
  end

  assign data_o  = data_q;
  assign spare_o = spare_q;

endmodule

`default_nettype wire

// ===== rtl/bll_chain.sv =====
// ----------------------------------------------------------------------------
// bll_chain
// ring of list cells with position decode, head word exposed for scans
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bll_chain import bll_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned CNT_BITS   = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire cell_op_e              op_i,
  input  wire logic [CNT_BITS-1:0]   pos_i,
  input  wire logic [DATA_WIDTH-1:0] key_i,
  output logic      [DATA_WIDTH-1:0] head_o
);

  logic [DATA_WIDTH-1:0] data_w  [CAPACITY];
  logic [DATA_WIDTH-1:0] spare_w [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] left, right, spare_left;

    assign ctl.op   = op_i;
    assign ctl.at   = (pos_i == CNT_BITS'(i));
    assign ctl.past = (CNT_BITS'(i) > pos_i);

    if (i == 0) begin : g_first
      assign left       = key_i;
      assign spare_left = data_w[0];
    end else begin : g_inner
      assign left       = data_w[i-1];
      assign spare_left = spare_w[i-1];
    end

    // last cell closes the ring back to the head
    if (i == CAPACITY - 1) begin : g_last
      assign right = data_w[0];
    end else begin : g_body
      assign right = data_w[i+1];
    end

    bll_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .key_i       (key_i),
      .left_i      (left),
      .right_i     (right),
      .spare_left_i(spare_left),
      .data_o      (data_w[i]),
      .spare_o     (spare_w[i])
    );
  end

  assign head_o = data_w[0];

endmodule

`default_nettype wire

// ===== rtl/bounded_linked_list_engine.sv =====
// results: push, pop, insert, erase, clear and rejected requests give the result in the cycle
//   after the transaction; find and read rotate the whole cell ring first; reverse streams
//   the list through the spare stack, and an empty reverse answers like a clear
// throughput: one request at a time, the next transaction is taken once the engine is
//   back in idle and the result register is free or draining
// reset: asynchronous active low, list empty, no result pending
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_linked_list_engine_macros.svh"

// ----------------------------------------------------------------------------
// bounded_linked_list_engine
// ordered list of up to CAPACITY words kept in a ring of shift cells
// ----------------------------------------------------------------------------
module bounded_linked_list_engine import bll_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // request stream
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // action[3:0], value[35:4], index[40:36], zero[47:41]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // result stream
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // status[1:0], found[2], read_data[34:3], count[39:35], empty_res[40], zero[47:41]
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_BITS = (CNT_BITS > INDEX_W) ? CNT_BITS : INDEX_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;  // rotate the ring once, look at the head
  localparam logic [1:0] ST_REV  = 2'd2;  // pop heads onto the spare stack
  localparam logic [1:0] ST_COPY = 2'd3;  // spare stack back into the list

  // request fields
  logic [ACTION_W-1:0] in_action;
  logic [VALUE_W-1:0]  in_value;
  logic [INDEX_W-1:0]  in_index;
  logic [DATA_WIDTH-1:0] in_key;

  assign in_action = s_axis_tdata_i[ACTION_W-1:0];
  assign in_value  = s_axis_tdata_i[ACTION_W +: VALUE_W];
  assign in_index  = s_axis_tdata_i[ACTION_W + VALUE_W +: INDEX_W];

  // data words keep the low DATA_WIDTH bits of value, zero-extended when wider
  if (DATA_WIDTH <= VALUE_W) begin : g_key_cut
    assign in_key = in_value[DATA_WIDTH-1:0];
  end else begin : g_key_ext
    assign in_key = {{(DATA_WIDTH - VALUE_W){1'b0}}, in_value};
  end

  // control state
  logic [1:0]          state_q, state_d;
  logic [CNT_BITS-1:0] step_q, step_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                m_valid_q, m_valid_d;

  // per-request scan context
  logic [DATA_WIDTH-1:0] key_q;
  logic [CMP_BITS-1:0]   idx_q;
  logic                  is_read_q;
  logic                  found_q, found_d;
  logic [VALUE_W-1:0]    rdata_q, rdata_d;

  // result register
  logic [STATUS_W-1:0] res_status_q, res_status;
  logic                res_found_q, res_found;
  logic [VALUE_W-1:0]  res_rdata_q, res_rdata;
  logic [COUNT_W-1:0]  res_count_q;
  logic                res_empty_q;
  logic                emit;

  // chain controls
  cell_op_e              op;
  logic [CNT_BITS-1:0]   pos;
  logic [DATA_WIDTH-1:0] chain_key;
  logic [DATA_WIDTH-1:0] head;
  logic [VALUE_W-1:0]    head_word;

  logic                acc;
  logic                full;
  logic                empty;
  logic [CMP_BITS-1:0] idx_ext;
  logic [CMP_BITS-1:0] cnt_ext;
  logic                hit;
  logic                grab;
  logic                scan_last;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  assign full    = (cnt_q == CNT_BITS'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign idx_ext = CMP_BITS'(in_index);
  assign cnt_ext = CMP_BITS'(cnt_q);

  // head word as read data
  if (DATA_WIDTH >= VALUE_W) begin : g_rd_cut
    assign head_word = head[VALUE_W-1:0];
  end else begin : g_rd_ext
    assign head_word = {{(VALUE_W - DATA_WIDTH){1'b0}}, head};
  end

  // during a scan the head cell holds list entry number step_q
  assign hit       = !is_read_q && (step_q < cnt_q) && (head == key_q);
  assign grab      = is_read_q && (CMP_BITS'(step_q) == idx_q);
  assign scan_last = (step_q == CNT_BITS'(CAPACITY - 1));

  assign chain_key = (state_q == ST_IDLE) ? in_key : key_q;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    rdata_d    = rdata_q;
    op         = CO_HOLD;
    pos        = '0;
    emit       = 1'b0;
    res_status = STAT_DONE;
    res_found  = 1'b0;
    res_rdata  = '0;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          found_d = 1'b0;
          rdata_d = '0;
          step_d  = '0;
          case (in_action)
            ACT_APPEND: begin
              emit = 1'b1;
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                op    = CO_INS;
                pos   = cnt_q;
                cnt_d = cnt_q + CNT_BITS'(1);
              end
            end
            ACT_PREPEND: begin
              emit = 1'b1;
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                op    = CO_INS;
                cnt_d = cnt_q + CNT_BITS'(1);
              end
            end
            ACT_DROP_TAIL: begin
              // tail entry simply drops out of the counted range
              emit = 1'b1;
              if (empty) begin
                res_status = STAT_BAD;
              end else begin
                cnt_d = cnt_q - CNT_BITS'(1);
              end
            end
            ACT_DROP_HEAD: begin
              emit = 1'b1;
              if (empty) begin
                res_status = STAT_BAD;
              end else begin
                op    = CO_DEL;
                cnt_d = cnt_q - CNT_BITS'(1);
              end
            end
            ACT_INSERT: begin
              emit = 1'b1;
              if (idx_ext > cnt_ext) begin
                res_status = STAT_BAD;
              end else if (full) begin
                res_status = STAT_FULL;
              end else begin
                op    = CO_INS;
                pos   = CNT_BITS'(in_index);
                cnt_d = cnt_q + CNT_BITS'(1);
              end
            end
            ACT_ERASE: begin
              emit = 1'b1;
              if (idx_ext >= cnt_ext) begin
                res_status = STAT_BAD;
              end else begin
                op    = CO_DEL;
                pos   = CNT_BITS'(in_index);
                cnt_d = cnt_q - CNT_BITS'(1);
              end
            end
            ACT_FIND: begin
              state_d = ST_SCAN;
            end
            ACT_REVERSE: begin
              if (empty) begin
                emit = 1'b1;
              end else begin
                state_d = ST_REV;
              end
            end
            ACT_READ: begin
              if (idx_ext >= cnt_ext) begin
                emit       = 1'b1;
                res_status = STAT_BAD;
              end else begin
                state_d = ST_SCAN;
              end
            end
            ACT_CLEAR: begin
              emit  = 1'b1;
              cnt_d = '0;
            end
            default: begin
              emit       = 1'b1;
              res_status = STAT_BAD;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // full ring rotation leaves the list in its original order
        op      = CO_DEL;
        found_d = found_q || hit;
        rdata_d = grab ? head_word : rdata_q;
        step_d  = step_q + CNT_BITS'(1);
        if (scan_last) begin
          emit      = 1'b1;
          res_found = found_d;
          res_rdata = rdata_d;
          state_d   = ST_IDLE;
        end
      end
      ST_REV: begin
        op     = CO_STACK;
        step_d = step_q + CNT_BITS'(1);
        if (step_q == cnt_q - CNT_BITS'(1)) begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        op      = CO_COPY;
        emit    = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    m_valid_d = emit || (m_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // request context and scan accumulators
  always_ff @(posedge clk_i) begin
    if (acc) begin
      key_q     <= in_key;
      idx_q     <= idx_ext;
      is_read_q <= (in_action == ACT_READ);
    end
    found_q <= found_d;
    rdata_q <= rdata_d;
  end

  // result register, count reflects the list after the action
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_status_q <= res_status;
      res_found_q  <= res_found;
      res_rdata_q  <= res_rdata;
      res_count_q  <= COUNT_W'(cnt_d);
      res_empty_q  <= (cnt_d == '0);
    end
  end

  bll_chain #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH),
    .CNT_BITS  (CNT_BITS)
  ) u_chain (
    .clk_i (clk_i),
    .op_i  (op),
    .pos_i (pos),
    .key_i (chain_key),
    .head_o(head)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {
    {(OUT_TDATA_W - STATUS_W - 1 - VALUE_W - COUNT_W - 1){1'b0}},
    res_empty_q, res_count_q, res_rdata_q, res_found_q, res_status_q
  };

  // entry count stays within the ring
  `BLL_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CNT_BITS'(CAPACITY), "count beyond capacity")
  // multi-cycle actions never change the entry count
  `BLL_ASSERT_NXT(a_busy_cnt, clk_i, rst_ni, state_q != ST_IDLE, $stable(cnt_q), "count moved while busy")
  // copy back of a reverse always ends in a result
  `BLL_ASSERT_NXT(a_copy_emit, clk_i, rst_ni, state_q == ST_COPY, m_axis_tvalid_o, "reverse lost its result")
  // end of a ring scan always ends in a result
  `BLL_ASSERT_NXT(a_scan_emit, clk_i, rst_ni, (state_q == ST_SCAN) && scan_last, m_axis_tvalid_o && (state_q == ST_IDLE), "scan lost its result")

endmodule

`default_nettype wire
